// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("implication failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle implication failed");

`endif

// ===== rtl/ideconf_pkg.sv =====
// ---------------------------------------------------------------------------
// ideconf_pkg
// Shared types and constants of the IDE controller config space unit.
// ---------------------------------------------------------------------------
package ideconf_pkg;

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_IRQ0   = 3'd2,
    OP_IRQ1   = 3'd3,
    OP_VENDOR = 3'd4,
    OP_RESET  = 3'd5
  } op_t;

  localparam logic [2:0] CFG_CHIP_VARIANT     = 3'd0;
  localparam logic [2:0] CFG_RAID_MODE        = 3'd1;
  localparam logic [2:0] CFG_SUBSYSTEM_RELOAD = 3'd2;
  localparam logic [2:0] CFG_BIOS_PRESENT     = 3'd3;
  localparam logic [2:0] CFG_PRIMARY_ONLY     = 3'd4;
  localparam logic [2:0] CFG_DEVICE_ENABLED   = 3'd5;
  localparam logic [2:0] CFG_PROG_IF_RESET    = 3'd6;
  localparam logic [2:0] CFG_ROM_SIZE_MASK    = 3'd7;

  typedef struct packed {
    logic [1:0]  chip_variant;
    logic        raid_mode;
    logic        subsystem_reload;
    logic        bios_present;
    logic        primary_only;
    logic        device_enabled;
    logic [7:0]  prog_if_reset;
    logic [15:0] rom_size_mask;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    chip_variant: 2'd0, raid_mode: 1'b0, subsystem_reload: 1'b0,
    bios_present: 1'b0, primary_only: 1'b0, device_enabled: 1'b1,
    prog_if_reset: 8'h8a, rom_size_mask: 16'h3fff
  };

  typedef struct packed {
    logic [2:0] opcode;
    logic [2:0] func;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] irq_status;
  } item_t;

  typedef struct packed {
    logic        rom_enable;
    logic [31:0] rom_base;
    logic        irq_forward;
    logic        busmaster_enable;
    logic [15:0] busmaster_base;
    logic [1:0]  channel_irq_modes;
    logic [1:0]  channel_enables;
    logic [15:0] secondary_ctrl_base;
    logic [15:0] secondary_cmd_base;
    logic [15:0] primary_ctrl_base;
    logic [15:0] primary_cmd_base;
    logic [7:0]  read_data;
  } res_t;

endpackage

// ===== rtl/ideconf_regs.sv =====
// ---------------------------------------------------------------------------
// ideconf_regs
// Strap and option registers written through the configuration port.
// ---------------------------------------------------------------------------
module ideconf_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [15:0]         cfg_wdata,
  output ideconf_pkg::cfg_t   cfg
);
  import ideconf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CHIP_VARIANT:     cfg.chip_variant     <= cfg_wdata[1:0];
        CFG_RAID_MODE:        cfg.raid_mode        <= cfg_wdata[0];
        CFG_SUBSYSTEM_RELOAD: cfg.subsystem_reload <= cfg_wdata[0];
        CFG_BIOS_PRESENT:     cfg.bios_present     <= cfg_wdata[0];
        CFG_PRIMARY_ONLY:     cfg.primary_only     <= cfg_wdata[0];
        CFG_DEVICE_ENABLED:   cfg.device_enabled   <= cfg_wdata[0];
        CFG_PROG_IF_RESET:    cfg.prog_if_reset    <= cfg_wdata[7:0];
        CFG_ROM_SIZE_MASK:    cfg.rom_size_mask    <= cfg_wdata;
        default:              cfg                  <= cfg;
      endcase
    end
  end

endmodule

// ===== rtl/ideconf_core.sv =====
// ---------------------------------------------------------------------------
// ideconf_core
// Config space byte registers, request execution and window decode.
// ---------------------------------------------------------------------------
module ideconf_core (
  input  logic                 clk,
  input  logic                 rst,
  input  ideconf_pkg::cfg_t    cfg,
  input  logic                 fire,
  input  ideconf_pkg::item_t   item,
  output ideconf_pkg::res_t    res
);
  import ideconf_pkg::*;

  // Only bytes that can ever be nonzero or that depend on straps are stored.
  typedef struct packed {
    logic [7:0] r02, r04, r05, r06, r07, r08, r09, r0a, r0b;
    logic [7:0] r10, r11, r14, r15, r18, r19, r1c, r1d, r20, r21;
    logic [7:0] r2c, r2d, r2e, r2f, r30, r31, r32, r33, r34, r3c, r4f;
    logic [7:0] r50, r51, r52, r53, r54, r55, r56, r57, r58, r59, r5b;
    logic [7:0] r60, r62, r63, r64, r65, r67;
    logic [7:0] r71, r72, r73, r79, r7a, r7b;
  } cs_t;

  function automatic cs_t mask_rom(cs_t c, cfg_t f);
    logic [31:0] w;
    logic [31:0] m;
    w = {c.r33, c.r32, c.r31, c.r30};
    m = {16'hffff, ~f.rom_size_mask[15:1], 1'b1};
    if ((f.chip_variant != 2'd0) && f.bios_present) begin
      w = w & m;
      {c.r33, c.r32, c.r31, c.r30} = w;
    end
    return c;
  endfunction

  function automatic cs_t load_defaults(cfg_t f);
    cs_t c;
    logic ext;
    logic newer;
    ext   = (f.chip_variant != 2'd0);
    newer = f.chip_variant[1];
    c = '0;
    c.r02 = newer ? 8'h49 : (ext ? 8'h48 : 8'h46);
    c.r07 = 8'h02;
    c.r09 = f.prog_if_reset;
    if (ext && f.raid_mode) begin
      c.r06 = 8'h90; c.r08 = 8'h02; c.r0a = 8'h04; c.r50 = 8'h40;
      c.r10 = 8'h01; c.r14 = 8'h01; c.r18 = 8'h01; c.r1c = 8'h01;
    end else begin
      c.r06 = 8'h80; c.r0a = 8'h01;
    end
    c.r0b = 8'h01;
    if (ext && f.subsystem_reload) begin
      c.r2c = 8'h95; c.r2d = 8'h10; c.r2e = c.r02; c.r2f = 8'h06;
    end
    // legacy-capable prog-if in IDE class gets native default bases
    if (c.r0a == 8'h01 && (c.r09 & 8'h8a) == 8'h8a) begin
      c.r50 = 8'h40;
      c.r10 = 8'hf1; c.r11 = 8'h01; c.r14 = 8'hf5; c.r15 = 8'h03;
      c.r18 = 8'h71; c.r19 = 8'h01; c.r1c = 8'h75; c.r1d = 8'h03;
    end
    c.r20 = 8'h01;
    c.r3c = 8'h0e;
    if (!f.primary_only) c.r51 = 8'h08;
    c.r57 = 8'h0c;
    if (ext) begin
      c.r34 = 8'h60;
      c.r4f = f.subsystem_reload ? 8'h02 : 8'h00;
      c.r51 = c.r51 | 8'h04;
      if (newer) begin
        c.r57 = c.r57 | 8'h80;
        c.r59 = 8'h40;
      end else begin
        c.r57 = c.r57 | 8'hc0;
      end
      c.r60 = 8'h01; c.r62 = 8'h21; c.r63 = 8'h06; c.r65 = 8'h60;
      c.r67 = 8'hf0; c.r72 = 8'h08; c.r7a = 8'h08; c.r79 = 8'h83;
    end else begin
      c.r59 = 8'h40;
    end
    return c;
  endfunction

  function automatic logic [7:0] cs_byte(cs_t c, logic [7:0] a);
    logic [7:0] d;
    unique case (a)
      8'h00: d = 8'h95;   8'h01: d = 8'h10;   8'h02: d = c.r02;
      8'h03: d = 8'h06;   8'h04: d = c.r04;   8'h05: d = c.r05;
      8'h06: d = c.r06;   8'h07: d = c.r07;   8'h08: d = c.r08;
      8'h09: d = c.r09;   8'h0a: d = c.r0a;   8'h0b: d = c.r0b;
      8'h10: d = c.r10;   8'h11: d = c.r11;   8'h14: d = c.r14;
      8'h15: d = c.r15;   8'h18: d = c.r18;   8'h19: d = c.r19;
      8'h1c: d = c.r1c;   8'h1d: d = c.r1d;   8'h20: d = c.r20;
      8'h21: d = c.r21;   8'h2c: d = c.r2c;   8'h2d: d = c.r2d;
      8'h2e: d = c.r2e;   8'h2f: d = c.r2f;   8'h30: d = c.r30;
      8'h31: d = c.r31;   8'h32: d = c.r32;   8'h33: d = c.r33;
      8'h34: d = c.r34;   8'h3c: d = c.r3c;   8'h3d: d = 8'h01;
      8'h3e: d = 8'h02;   8'h3f: d = 8'h04;   8'h4f: d = c.r4f;
      8'h50: d = c.r50;   8'h51: d = c.r51;   8'h52: d = c.r52;
      8'h53: d = c.r53;   8'h54: d = c.r54;   8'h55: d = c.r55;
      8'h56: d = c.r56;   8'h57: d = c.r57;   8'h58: d = c.r58;
      8'h59: d = c.r59;   8'h5b: d = c.r5b;   8'h60: d = c.r60;
      8'h62: d = c.r62;   8'h63: d = c.r63;   8'h64: d = c.r64;
      8'h65: d = c.r65;   8'h67: d = c.r67;   8'h71: d = c.r71;
      8'h72: d = c.r72;   8'h73: d = c.r73;   8'h79: d = c.r79;
      8'h7a: d = c.r7a;   8'h7b: d = c.r7b;
      default: d = 8'h00;
    endcase
    return d;
  endfunction

  function automatic cs_t set_subsys(cs_t c, logic [1:0] i, logic [7:0] v);
    unique case (i)
      2'd0: c.r2c = v;
      2'd1: c.r2d = v;
      2'd2: c.r2e = v;
      default: c.r2f = v;
    endcase
    return c;
  endfunction

  function automatic cs_t cs_write(cs_t c, cfg_t f, logic [7:0] a, logic [7:0] v);
    logic ext;
    logic newer;
    logic unlock;
    ext    = (f.chip_variant != 2'd0);
    newer  = f.chip_variant[1];
    unlock = c.r50[6] || (ext && c.r0a == 8'h04 && c.r0b == 8'h01);
    unique case (a)
      8'h04: begin
        c.r04 = v & (f.bios_present ? 8'h47 : 8'h45);
        c = mask_rom(c, f);
      end
      8'h05: if (ext) c.r05 = (c.r05 & 8'h7e) | (v & 8'h01);
      8'h07: begin
        if (ext) c.r07 = ((c.r07 & ~(v & 8'hb9)) & 8'hbf) | (v & 8'h40);
        else c.r07 = c.r07 & ~(v & 8'hb1);
      end
      8'h09: begin
        if ((!ext || (c.r0a == 8'h01 && c.r0b == 8'h01)) && (c.r09 & 8'h0a) == 8'h0a)
          c.r09 = (c.r09 & 8'h8a) | (v & 8'h05);
      end
      8'h0a: if (ext && c.r4f[2]) c.r0a = v;
      8'h0b: if (ext && c.r4f[2]) c.r0b = v;
      8'h10: if (unlock) c.r10 = (v & 8'hf8) | 8'h01;
      8'h18: if (unlock) c.r18 = (v & 8'hf8) | 8'h01;
      8'h14: if (unlock) c.r14 = (v & 8'hfc) | 8'h01;
      8'h1c: if (unlock) c.r1c = (v & 8'hfc) | 8'h01;
      8'h11: if (unlock) c.r11 = v;
      8'h15: if (unlock) c.r15 = v;
      8'h19: if (unlock) c.r19 = v;
      8'h1d: if (unlock) c.r1d = v;
      8'h20: c.r20 = (v & 8'hf0) | 8'h01;
      8'h21: c.r21 = v;
      8'h3c: c.r3c = v;
      8'h2c, 8'h2d, 8'h2e, 8'h2f, 8'h8c, 8'h8d, 8'h8e, 8'h8f:
        if (ext) c = set_subsys(c, a[1:0], v);
      8'h30, 8'h31, 8'h32, 8'h33: begin
        if (ext && f.bios_present) begin
          unique case (a[1:0])
            2'd0: c.r30 = v;
            2'd1: c.r31 = v;
            2'd2: c.r32 = v;
            default: c.r33 = v;
          endcase
          c = mask_rom(c, f);
        end
      end
      8'h4f: if (ext) c.r4f = (c.r4f & 8'hfa) | (v & 8'h05);
      8'h51: c.r51 = v & (ext ? 8'hcc : 8'hc8);
      8'h52: c.r52 = v;
      8'h54: c.r54 = v;
      8'h56: c.r56 = v;
      8'h58: c.r58 = v;
      8'h5b: c.r5b = v;
      8'h59: if (newer || !ext) c.r59 = v;
      8'h53: c.r53 = v & 8'hc0;
      8'h55: c.r55 = v & 8'hc0;
      8'h57: c.r57 = (c.r57 & 8'h10) | (v & 8'hcc);
      8'h64: if (ext) c.r64 = (c.r64 & 8'hfc) | (v & 8'h03);
      8'h65: if (ext) c.r65 = (c.r65 & 8'h7f) | (v & 8'h80);
      default: c = c;
    endcase
    return c;
  endfunction

  cs_t        cs;
  cs_t        cs_next;
  logic       ext;
  logic       raid;
  logic       rom_act;
  logic       live;
  logic [7:0] rd;
  logic       fwd;
  logic [7:0] p9;
  logic [7:0] p50;
  logic [31:0] rom_w;

  assign ext     = (cfg.chip_variant != 2'd0);
  assign raid    = ext && cfg.raid_mode;
  assign rom_act = ext && cfg.bios_present;
  assign live    = cfg.device_enabled && (item.func == 3'd0);

  always_comb begin
    cs_next = cs;
    rd      = 8'h00;
    fwd     = 1'b0;
    case (op_t'(item.opcode))
      OP_READ: begin
        if (live) begin
          rd = cs_byte(cs, item.reg_addr);
          if (item.reg_addr == 8'h09 && ext && cs.r0a == 8'h04) rd = 8'h00;
          else if (item.reg_addr == 8'h50) cs_next.r50[2] = 1'b0;
          else if (item.reg_addr == 8'h57) cs_next.r57[4] = 1'b0;
          else if (ext && item.reg_addr[7:2] == 6'b100011)
            rd = cs_byte(cs, {6'b001011, item.reg_addr[1:0]});
        end else begin
          rd = 8'hff;
        end
      end
      OP_WRITE: if (live) cs_next = cs_write(cs, cfg, item.reg_addr, item.write_data);
      OP_IRQ0: begin
        // latch holds until read or a vendor clear, unless a new interrupt is flagged
        if (!cs.r50[2] || item.irq_status[2])
          cs_next.r50 = (cs.r50 & 8'hfb) | item.irq_status;
        fwd = !ext || !cs.r71[4];
      end
      OP_IRQ1: begin
        if (!cfg.primary_only) begin
          if (!cs.r57[4] || item.irq_status[2])
            cs_next.r57 = (cs.r57 & 8'hef) | {item.irq_status[5:0], 2'b00};
          fwd = !ext || !cs.r71[5];
        end
      end
      OP_VENDOR: begin
        rd = item.write_data;
        if (ext) begin
          case (item.reg_addr[3:0])
            4'h1: begin
              cs_next.r71 = item.write_data & 8'hf0;
              if (item.write_data[2]) cs_next.r50[2] = 1'b0;
              if (item.write_data[3]) cs_next.r57[4] = 1'b0;
              rd = item.write_data & 8'h03;
            end
            4'h3: cs_next.r73 = item.write_data;
            4'h9: begin
              cs_next.r79 = (cs.r79 & 8'h0f) | (item.write_data & 8'hf0);
              rd = item.write_data & 8'h03;
            end
            4'hb: cs_next.r7b = item.write_data;
            default: cs_next = cs;
          endcase
        end
      end
      OP_RESET: cs_next = mask_rom(load_defaults(cfg), cfg);
      default: cs_next = cs;
    endcase
  end

  // window decode on the updated registers
  always_comb begin
    p9  = raid ? 8'hff : cs_next.r09;
    p50 = raid ? (cs_next.r50 | 8'h40) : cs_next.r50;
    rom_w = {cs_next.r33, cs_next.r32, cs_next.r31, cs_next.r30};
    res = '0;
    res.read_data = rd;
    res.irq_forward = fwd;
    if (p9[0] && p50[6]) begin
      res.primary_cmd_base  = {cs_next.r11, cs_next.r10 & 8'hf8};
      res.primary_ctrl_base = {cs_next.r15, cs_next.r14 & 8'hfc} + 16'd2;
    end else begin
      res.primary_cmd_base  = 16'h01f0;
      res.primary_ctrl_base = 16'h03f6;
    end
    res.channel_irq_modes[0] = p9[0];
    res.channel_enables[0] = cfg.device_enabled && cs_next.r04[0] &&
                             (!ext || cs_next.r51[2]);
    if (!cfg.primary_only) begin
      if (p9[2] && p50[6]) begin
        res.secondary_cmd_base  = {cs_next.r19, cs_next.r18 & 8'hf8};
        res.secondary_ctrl_base = {cs_next.r1d, cs_next.r1c & 8'hfc} + 16'd2;
      end else begin
        res.secondary_cmd_base  = 16'h0170;
        res.secondary_ctrl_base = 16'h0376;
      end
      res.channel_irq_modes[1] = p9[2];
      res.channel_enables[1] = cfg.device_enabled && cs_next.r04[0] && cs_next.r51[3];
    end
    res.busmaster_base   = {cs_next.r21, cs_next.r20 & 8'hf0};
    res.busmaster_enable = cfg.device_enabled && cs_next.r04[0];
    if (rom_act) begin
      res.rom_base   = rom_w & 32'hfffffff0;
      res.rom_enable = cs_next.r04[1] && rom_w[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cs <= mask_rom(load_defaults(CFG_RESET), CFG_RESET);
    end else if (fire) begin
      cs <= cs_next;
    end
  end

endmodule

// ===== rtl/pci_ide_controller_config_space_unit.sv =====
// ---------------------------------------------------------------------------
// pci_ide_controller_config_space_unit
// Config space of a dual-channel IDE controller with window decode.
// ---------------------------------------------------------------------------
//  channel  | dir | contents
//  s_*      | in  | one request: opcode, function, offset, data, irq status
//  m_*      | out | read data and decoded windows, one per request
//  cfg_*    | in  | strap/option register writes, index 0..7
//
//  One request per cycle sustained while m_* is not stalled; a taken request is
//  held in the input stage, and the result register and m_tvalid load when it fires.
//  The config-space byte update and decode sit between the two registers.
//  Synchronous reset loads the strap defaults; no clearing pass.
//  A stalled m_* holds; s_tready drops only while both stages are full.
// ---------------------------------------------------------------------------
module pci_ide_controller_config_space_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // opcode[2:0] func[5:3] reg_addr[13:6] write_data[21:14] irq_status[29:22]
  input  logic [31:0]   s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // read_data[7:0] primary_cmd_base[23:8] primary_ctrl_base[39:24]
  // secondary_cmd_base[55:40] secondary_ctrl_base[71:56]
  // channel_enables[73:72] channel_irq_modes[75:74] busmaster_base[91:76]
  // busmaster_enable[92] irq_forward[93] rom_base[125:94] rom_enable[126]
  output logic [127:0]  m_tdata,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [15:0]   cfg_wdata
);
  import ideconf_pkg::*;

  `include "assert_macros.svh"

  cfg_t  cfg;
  item_t q_item;
  logic  q_valid;
  logic  out_free;
  logic  fire;
  logic  s_accept;
  res_t  res;

  assign out_free = !m_tvalid || m_tready;
  assign fire     = q_valid && out_free;
  assign s_tready = !q_valid || out_free;
  assign s_accept = s_tvalid && s_tready;

  ideconf_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ideconf_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (fire),
    .item (q_item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (s_accept) begin
      q_valid <= 1'b1;
    end else if (fire) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      q_item <= '{opcode: s_tdata[2:0], func: s_tdata[5:3], reg_addr: s_tdata[13:6],
                  write_data: s_tdata[21:14], irq_status: s_tdata[29:22]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {1'b0, res};
    end
  end

  `ASSERT_IMPL(a_ready_only_when_full, clk, rst, !s_tready, q_valid)
  `ASSERT_NEXT(a_fire_gives_result, clk, rst, fire, m_tvalid)
  `ASSERT_NEXT(a_stage_holds, clk, rst, q_valid && !out_free, q_valid && $stable(q_item))
  `ASSERT_IMPL(a_fwd_only_irq, clk, rst, fire && res.irq_forward,
    q_item.opcode == OP_IRQ0 || q_item.opcode == OP_IRQ1)

endmodule
